// ----- src/ep2cal_pkg.sv -----
package ep2cal_pkg;

	// day split: t / 86400 = (t >> 7) / 675
	localparam int unsigned DAY_SHIFT       = 7;
	localparam logic [9:0]  DAY_ODD         = 10'd675;
	localparam logic [30:0] DAY_RECIP       = 31'd1628906115;  // floor(2^40 / 675)
	localparam int unsigned DAY_RECIP_SHIFT = 40;

	// time of day
	localparam logic [11:0] SECS_PER_HOUR   = 12'd3600;
	localparam logic [15:0] HOUR_RECIP      = 16'd37283;       // ceil(2^27 / 3600)
	localparam int unsigned HOUR_SHIFT      = 27;
	localparam logic [5:0]  SECS_PER_MIN    = 6'd60;
	localparam logic [12:0] MIN_RECIP       = 13'd4370;        // ceil(2^18 / 60)
	localparam int unsigned MIN_SHIFT       = 18;

	// weekday: (days + 4) mod 7, 1970-01-01 is a thursday
	localparam logic [2:0]  EPOCH_WEEKDAY   = 3'd4;
	localparam logic [2:0]  DAYS_PER_WEEK   = 3'd7;
	localparam logic [16:0] WEEK_RECIP      = 17'd74899;       // ceil(2^19 / 7)
	localparam int unsigned WEEK_SHIFT      = 19;

	// date: four-year cycles counted from 1968-03-01
	localparam logic [15:0] DAY_2100_MAR01  = 16'd47541;       // days from 1970-01-01
	localparam logic [9:0]  BASE_OFFSET     = 10'd671;         // 1968-03-01 to 1970-01-01
	localparam logic [10:0] DAYS_PER_CYCLE  = 11'd1461;
	localparam logic [15:0] CYCLE_RECIP     = 16'd45934;       // ceil(2^26 / 1461)
	localparam int unsigned CYCLE_SHIFT     = 26;
	localparam logic [8:0]  DAYS_PER_YEAR   = 9'd365;
	localparam logic [11:0] BASE_YEAR       = 12'd1968;

	// march-based month starts, index 0 is march, 10 january, 11 february
	localparam logic [8:0] MON_START [12] = '{
		9'd0, 9'd31, 9'd61, 9'd92, 9'd122, 9'd153,
		9'd184, 9'd214, 9'd245, 9'd275, 9'd306, 9'd337
	};
	localparam logic [3:0] MP_JANUARY = 4'd10;

	// zone offset after reset, eight hours
	localparam logic signed [16:0] ZONE_RESET = 17'sd28800;

endpackage

// ----- src/ep2cal_split.sv -----
module ep2cal_split
	import ep2cal_pkg::*;
(
	input  logic               clk,
	input  logic               adv,
	input  logic [31:0]        epoch_seconds,
	input  logic signed [16:0] zone,
	output logic [15:0]        days_s3,
	output logic [16:0]        hms_s3
);

	logic [31:0] t_s1;
	logic [31:0] t_s2;
	logic [55:0] prod_s2;

	logic [15:0] q0;
	logic [24:0] x;
	logic [25:0] qm;
	logic [10:0] r_raw;
	logic        r_ge;

	// quotient estimate is exact or one low, one compare fixes it
	always_comb begin
		q0    = prod_s2[DAY_RECIP_SHIFT +: 16];
		x     = t_s2[31:DAY_SHIFT];
		qm    = 26'(q0) * 26'(DAY_ODD);
		r_raw = 11'(26'(x) - qm);
		r_ge  = (r_raw >= 11'(DAY_ODD));
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s1    <= epoch_seconds + {{15{zone[16]}}, zone};
			t_s2    <= t_s1;
			prod_s2 <= 56'(t_s1[31:DAY_SHIFT]) * 56'(DAY_RECIP);
			days_s3 <= r_ge ? q0 + 16'd1 : q0;
			hms_s3  <= {(r_ge ? 10'(r_raw - 11'(DAY_ODD)) : r_raw[9:0]), t_s2[DAY_SHIFT-1:0]};
		end
	end

endmodule

// ----- src/ep2cal_tod.sv -----
module ep2cal_tod
	import ep2cal_pkg::*;
(
	input  logic        clk,
	input  logic        adv,
	input  logic [16:0] hms_s3,
	output logic [4:0]  hour_s8,
	output logic [5:0]  minute_s8,
	output logic [5:0]  second_s8
);

	logic [32:0] hprod;
	logic [24:0] mprod;

	logic [16:0] hms_s4;
	logic [4:0]  hour_s4, hour_s5, hour_s6, hour_s7;
	logic [11:0] rh_s5, rh_s6;
	logic [5:0]  min_s6, min_s7;
	logic [5:0]  sec_s7;

	always_comb begin
		hprod = 33'(hms_s3) * 33'(HOUR_RECIP);
		mprod = 25'(rh_s5) * 25'(MIN_RECIP);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hms_s4    <= hms_s3;
			hour_s4   <= hprod[HOUR_SHIFT +: 5];
			hour_s5   <= hour_s4;
			rh_s5     <= 12'(hms_s4 - 17'(hour_s4) * 17'(SECS_PER_HOUR));
			hour_s6   <= hour_s5;
			rh_s6     <= rh_s5;
			min_s6    <= mprod[MIN_SHIFT +: 6];
			hour_s7   <= hour_s6;
			min_s7    <= min_s6;
			sec_s7    <= 6'(rh_s6 - 12'(min_s6) * 12'(SECS_PER_MIN));
			hour_s8   <= hour_s7;
			minute_s8 <= min_s7;
			second_s8 <= sec_s7;
		end
	end

endmodule

// ----- src/ep2cal_date.sv -----
module ep2cal_date
	import ep2cal_pkg::*;
(
	input  logic        clk,
	input  logic        adv,
	input  logic [15:0] days_s3,
	output logic [11:0] year_s8,
	output logic [3:0]  month_s8,
	output logic [4:0]  dom_s8,
	output logic [2:0]  weekday_s8
);

	logic [15:0] wx;
	logic [32:0] wprod;
	logic [31:0] cprod;

	logic [15:0] z_s4, z_s5;
	logic [15:0] wx_s4;
	logic [12:0] wq_s4;
	logic [5:0]  cq_s5, cq_s6;
	logic [2:0]  wk_s5, wk_s6, wk_s7;
	logic [10:0] r_s6;
	logic [8:0]  doy_s7;
	logic [11:0] yearm_s7;

	logic [1:0]  yoc;
	logic [3:0]  mp;

	always_comb begin
		wx    = days_s3 + 16'(EPOCH_WEEKDAY);
		wprod = 33'(wx) * 33'(WEEK_RECIP);
		cprod = 32'(z_s4) * 32'(CYCLE_RECIP);
	end

	// year within the four-year cycle, the last one is the leap year
	always_comb begin
		priority if (r_s6 >= 11'(3 * DAYS_PER_YEAR)) yoc = 2'd3;
		else if (r_s6 >= 11'(2 * DAYS_PER_YEAR))     yoc = 2'd2;
		else if (r_s6 >= 11'(DAYS_PER_YEAR))         yoc = 2'd1;
		else                                          yoc = 2'd0;
	end

	// starts rise monotonically, so the last hit is the month
	always_comb begin
		mp = 4'd0;
		for (int i = 1; i < 12; i++) begin
			if (doy_s7 >= MON_START[i]) mp = 4'(i);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// a phantom feb 29 in 2100 keeps the plain four-year rule valid
			z_s4       <= days_s3 + 16'(days_s3 >= DAY_2100_MAR01) + 16'(BASE_OFFSET);
			wx_s4      <= wx;
			wq_s4      <= wprod[WEEK_SHIFT +: 13];
			z_s5       <= z_s4;
			cq_s5      <= cprod[CYCLE_SHIFT +: 6];
			wk_s5      <= 3'(wx_s4 - 16'(wq_s4) * 16'(DAYS_PER_WEEK));
			cq_s6      <= cq_s5;
			r_s6       <= 11'(z_s5 - 16'(cq_s5) * 16'(DAYS_PER_CYCLE));
			wk_s6      <= wk_s5;
			doy_s7     <= 9'(r_s6 - 11'(yoc) * 11'(DAYS_PER_YEAR));
			yearm_s7   <= BASE_YEAR + {4'd0, cq_s6, 2'd0} + 12'(yoc);
			wk_s7      <= wk_s6;
			year_s8    <= yearm_s7 + 12'(mp >= MP_JANUARY);
			month_s8   <= (mp < MP_JANUARY) ? mp + 4'd3 : mp - 4'd9;
			dom_s8     <= 5'(doy_s7 - MON_START[mp] + 9'd1);
			weekday_s8 <= wk_s7;
		end
	end

endmodule

// ----- src/epoch_seconds_to_calendar_unit.sv -----
// Converts a 32-bit count of seconds since 1970-01-01 00:00:00 into local calendar
// fields: year, month, day_of_month, hour, minute, second and weekday (0 is sunday).
// The signed 17-bit zone offset (reset value 28800, eight hours) is added first and
// the sum wraps modulo 2^32, so every result lies between 1970-01-01 and 2106-02-07.
// Leap years follow the full gregorian rule, 2100 is not a leap year. The block is
// an eight-stage pipeline: an accepted item passes through the stage registers s1 to
// s8 and its result is shown from the s8 registers, and a new item can enter
// every cycle unless the output stalls. The output register holds a result until it
// is taken; while it waits, the whole pipeline holds and in_ready is low. Write the
// zone offset only while no items are in flight.
module epoch_seconds_to_calendar_unit
	import ep2cal_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// configuration
	input  logic               cfg_we,
	input  logic signed [16:0] cfg_wdata,
	// input item
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [31:0]        epoch_seconds,
	// result item
	output logic               out_valid,
	input  logic               out_ready,
	output logic [11:0]        year,
	output logic [3:0]         month,
	output logic [4:0]         day_of_month,
	output logic [4:0]         hour,
	output logic [5:0]         minute,
	output logic [5:0]         second,
	output logic [2:0]         weekday
);

	logic signed [16:0] zone_q;

	// one valid bit per stage, all stages move together
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic adv;

	logic [15:0] days_s3;
	logic [16:0] hms_s3;

	// pipeline moves unless a finished result sits unclaimed
	assign adv       = !v_s8 || out_ready;
	assign in_ready  = adv;
	assign out_valid = v_s8;

	// zone offset register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zone_q <= ZONE_RESET;
		end else if (cfg_we) begin
			zone_q <= cfg_wdata;
		end
	end

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	// stages 1-3: zone add, reciprocal multiply by 1/675, remainder fix-up
	ep2cal_split u_split (
		.clk           (clk),
		.adv           (adv),
		.epoch_seconds (epoch_seconds),
		.zone          (zone_q),
		.days_s3       (days_s3),
		.hms_s3        (hms_s3)
	);

	// stages 4-8: seconds of day into hour, minute, second
	ep2cal_tod u_tod (
		.clk       (clk),
		.adv       (adv),
		.hms_s3    (hms_s3),
		.hour_s8   (hour),
		.minute_s8 (minute),
		.second_s8 (second)
	);

	// stages 4-8: day count into year, month, day and weekday
	ep2cal_date u_date (
		.clk        (clk),
		.adv        (adv),
		.days_s3    (days_s3),
		.year_s8    (year),
		.month_s8   (month),
		.dom_s8     (day_of_month),
		.weekday_s8 (weekday)
	);

endmodule

// ----- src/ep2cal_checker.sv -----
module ep2cal_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [11:0] year,
	input logic [3:0]  month,
	input logic [4:0]  day_of_month,
	input logic [4:0]  hour,
	input logic [5:0]  minute,
	input logic [5:0]  second,
	input logic [2:0]  weekday
);

	// held result keeps its fields
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(year) && $stable(month) &&
		$stable(day_of_month) && $stable(hour) && $stable(minute) && $stable(second) &&
		$stable(weekday))
		else $error("result changed while stalled");

	// an empty output stage never blocks the input
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty output");

	a_date: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> year >= 12'd1970 && year <= 12'd2106 && month >= 4'd1 &&
		month <= 4'd12 && day_of_month >= 5'd1 && day_of_month <= 5'd31)
		else $error("date out of range");

	a_time: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> hour <= 5'd23 && minute <= 6'd59 && second <= 6'd59 &&
		weekday <= 3'd6)
		else $error("time or weekday out of range");

	// february never passes 29, and 2100 has no leap day
	a_feb: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && month == 4'd2 |-> day_of_month <= 5'd29 &&
		(year != 12'd2100 || day_of_month <= 5'd28))
		else $error("bad february day");

endmodule

bind epoch_seconds_to_calendar_unit ep2cal_checker u_ep2cal_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.year         (year),
	.month        (month),
	.day_of_month (day_of_month),
	.hour         (hour),
	.minute       (minute),
	.second       (second),
	.weekday      (weekday)
);
